// ===== rtl/printf_format_spec_counter_core_assert.svh =====
// ---------------------------------------------------------------------------
// printf format specifier counter - assertion macros
// concurrent checks clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef PRINTF_FORMAT_SPEC_COUNTER_CORE_ASSERT_SVH
`define PRINTF_FORMAT_SPEC_COUNTER_CORE_ASSERT_SVH

// same-cycle implication
`define PFSC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfsc_pkg.sv =====
// ---------------------------------------------------------------------------
// pfsc_pkg - shared types and constants
// widths, character codes, controller/datapath command and status structs
// ---------------------------------------------------------------------------
package pfsc_pkg;

  localparam int CNT_W     = 16;
  localparam int OUT_W     = 16;
  localparam int PROD_W    = CNT_W + 4;
  localparam int DIV_STEPS = 20;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [OUT_W-1:0]     CONF_HALF = 16'd32768;
  localparam logic [OUT_W-1:0]     CONF_MAX  = 16'd62259;
  localparam logic [DIV_STEPS-1:0] CONF_SPAN = DIV_STEPS'(29491);
  localparam logic [CNT_W-1:0]     CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_J  = 8'h6A;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_UP_L   = 8'h4C;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_flag(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
           (c == CH_HASH) || (c == CH_ZERO) || (c == CH_QUOTE);
  endfunction

  function automatic logic is_conv(input logic [7:0] c);
    logic r;
    case (c)
      8'h64, 8'h69, 8'h75, 8'h6F, 8'h78, 8'h58,
      8'h66, 8'h46, 8'h65, 8'h45, 8'h67, 8'h47,
      8'h61, 8'h41, 8'h63, 8'h73, 8'h70, 8'h6E, 8'h6D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [CNT_W-1:0] x);
    logic [CNT_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, x};
    return (w > (CNT_W+OUT_W)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/pfsc_text_if.sv =====
// ---------------------------------------------------------------------------
// pfsc_text_if - input byte channel
// valid/ready handshake carrying one text byte and an end-of-string mark
// ---------------------------------------------------------------------------
interface pfsc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ===== rtl/pfsc_result_if.sv =====
// ---------------------------------------------------------------------------
// pfsc_result_if - result channel
// valid/ready handshake carrying the per-string summary
// ---------------------------------------------------------------------------
interface pfsc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] spec_count;
  logic        is_format;
  logic [15:0] confidence_q16;
  logic [15:0] text_length;

  modport source (output valid, output spec_count, output is_format,
                  output confidence_q16, output text_length, input ready);
  modport sink   (input valid, input spec_count, input is_format,
                  input confidence_q16, input text_length, output ready);
endinterface

// ===== rtl/pfsc_datapath.sv =====
// ---------------------------------------------------------------------------
// pfsc_datapath - specifier recognizer, counters and confidence divider
// per-byte parse state, saturating counters, restoring divider, result regs
// ---------------------------------------------------------------------------
module pfsc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   text_byte,
  input  logic                         last_byte,
  input  pfsc_pkg::cmd_t               cmd,
  output pfsc_pkg::status_t            status,
  output logic [pfsc_pkg::OUT_W-1:0]   spec_count,
  output logic                         is_format,
  output logic [pfsc_pkg::OUT_W-1:0]   confidence_q16,
  output logic [pfsc_pkg::OUT_W-1:0]   text_length
);

  typedef enum logic [11:0] {
    PH_IDLE   = 12'b0000_0000_0001,
    PH_PCT    = 12'b0000_0000_0010,
    PH_POSDIG = 12'b0000_0000_0100,
    PH_FLAGS  = 12'b0000_0000_1000,
    PH_WIDTH  = 12'b0000_0001_0000,
    PH_AWIDTH = 12'b0000_0010_0000,
    PH_DOT    = 12'b0000_0100_0000,
    PH_PREC   = 12'b0000_1000_0000,
    PH_APREC  = 12'b0001_0000_0000,
    PH_H1     = 12'b0010_0000_0000,
    PH_L1     = 12'b0100_0000_0000,
    PH_LEN    = 12'b1000_0000_0000
  } phase_t;

  phase_t                          phase;
  phase_t                          phase_next;
  phase_t                          st;
  logic                            lead_zero;
  logic                            lead_zero_next;
  logic                            hold;
  logic                            hit;
  logic [pfsc_pkg::CNT_W-1:0]      found;
  logic [pfsc_pkg::CNT_W-1:0]      total;
  logic [pfsc_pkg::CNT_W-1:0]      found_next;
  logic [pfsc_pkg::CNT_W-1:0]      total_next;
  logic [pfsc_pkg::PROD_W-1:0]     prod;
  logic [pfsc_pkg::CNT_W-1:0]      found_cap;
  logic [pfsc_pkg::CNT_W-1:0]      total_cap;
  logic [pfsc_pkg::CNT_W-1:0]      rem;
  logic [pfsc_pkg::CNT_W-1:0]      rem_next;
  logic [pfsc_pkg::CNT_W:0]        trial;
  logic                            qbit;
  logic [pfsc_pkg::DIV_STEPS-1:0]  quo;
  logic [pfsc_pkg::STEP_W-1:0]     step_cnt;
  logic [pfsc_pkg::OUT_W-1:0]      conf;

  always_comb begin
    st             = phase;
    phase_next     = PH_IDLE;
    lead_zero_next = lead_zero;
    hold           = 1'b0;
    hit            = 1'b0;
    if (st == PH_PCT) begin
      if (text_byte == pfsc_pkg::CH_PCT) begin
        phase_next = PH_IDLE;
        hold       = 1'b1;
      end else if (pfsc_pkg::is_digit(text_byte)) begin
        lead_zero_next = (text_byte == pfsc_pkg::CH_ZERO);
        phase_next     = PH_POSDIG;
        hold           = 1'b1;
      end else begin
        st = PH_FLAGS;
      end
    end
    if (!hold && st == PH_POSDIG) begin
      if (pfsc_pkg::is_digit(text_byte)) begin
        lead_zero_next = lead_zero & (text_byte == pfsc_pkg::CH_ZERO);
        phase_next     = PH_POSDIG;
        hold           = 1'b1;
      end else if (text_byte == pfsc_pkg::CH_DOLLAR) begin
        phase_next = PH_FLAGS;
        hold       = 1'b1;
      end else begin
        st = lead_zero ? PH_FLAGS : PH_AWIDTH;
      end
    end
    if (!hold && st == PH_FLAGS) begin
      if (pfsc_pkg::is_flag(text_byte)) begin
        phase_next = PH_FLAGS;
        hold       = 1'b1;
      end else if (text_byte == pfsc_pkg::CH_STAR) begin
        phase_next = PH_AWIDTH;
        hold       = 1'b1;
      end else if (pfsc_pkg::is_digit(text_byte)) begin
        phase_next = PH_WIDTH;
        hold       = 1'b1;
      end else begin
        st = PH_AWIDTH;
      end
    end
    if (!hold && st == PH_WIDTH) begin
      if (pfsc_pkg::is_digit(text_byte)) begin
        phase_next = PH_WIDTH;
        hold       = 1'b1;
      end else begin
        st = PH_AWIDTH;
      end
    end
    if (!hold && st == PH_AWIDTH) begin
      if (text_byte == pfsc_pkg::CH_DOT) begin
        phase_next = PH_DOT;
        hold       = 1'b1;
      end else begin
        st = PH_APREC;
      end
    end
    if (!hold && st == PH_DOT) begin
      if (text_byte == pfsc_pkg::CH_STAR) begin
        phase_next = PH_APREC;
        hold       = 1'b1;
      end else if (pfsc_pkg::is_digit(text_byte)) begin
        phase_next = PH_PREC;
        hold       = 1'b1;
      end else begin
        st = PH_APREC;
      end
    end
    if (!hold && st == PH_PREC) begin
      if (pfsc_pkg::is_digit(text_byte)) begin
        phase_next = PH_PREC;
        hold       = 1'b1;
      end else begin
        st = PH_APREC;
      end
    end
    if (!hold && st == PH_APREC) begin
      if (text_byte == pfsc_pkg::CH_LOW_H) begin
        phase_next = PH_H1;
        hold       = 1'b1;
      end else if (text_byte == pfsc_pkg::CH_LOW_L) begin
        phase_next = PH_L1;
        hold       = 1'b1;
      end else if (text_byte == pfsc_pkg::CH_LOW_J || text_byte == pfsc_pkg::CH_LOW_Z ||
                   text_byte == pfsc_pkg::CH_LOW_T || text_byte == pfsc_pkg::CH_UP_L) begin
        phase_next = PH_LEN;
        hold       = 1'b1;
      end else begin
        st = PH_LEN;
      end
    end
    if (!hold && st == PH_H1) begin
      if (text_byte == pfsc_pkg::CH_LOW_H) begin
        phase_next = PH_LEN;
        hold       = 1'b1;
      end else begin
        st = PH_LEN;
      end
    end
    if (!hold && st == PH_L1) begin
      if (text_byte == pfsc_pkg::CH_LOW_L) begin
        phase_next = PH_LEN;
        hold       = 1'b1;
      end else begin
        st = PH_LEN;
      end
    end
    if (!hold && st == PH_LEN) begin
      if (pfsc_pkg::is_conv(text_byte)) begin
        hit        = 1'b1;
        phase_next = PH_IDLE;
        hold       = 1'b1;
      end
    end
    // idle, or a failed specifier resuming at this byte
    if (!hold) begin
      phase_next = (text_byte == pfsc_pkg::CH_PCT) ? PH_PCT : PH_IDLE;
    end
  end

  assign found_next = (hit && found != pfsc_pkg::CNT_MAX) ? found + 1'b1 : found;
  assign total_next = (total != pfsc_pkg::CNT_MAX) ? total + 1'b1 : total;

  // count * 10 ahead of the divide by length
  assign prod = ({4'b0, found_next} << 3) + ({4'b0, found_next} << 1);

  assign trial    = {rem, quo[pfsc_pkg::DIV_STEPS-1]};
  assign qbit     = trial >= {1'b0, total_cap};
  assign rem_next = qbit ? pfsc_pkg::CNT_W'(trial - {1'b0, total_cap})
                         : trial[pfsc_pkg::CNT_W-1:0];

  assign status.div_last = (step_cnt == '0);

  always_comb begin
    if (found_cap == '0) begin
      conf = '0;
    end else if (quo >= pfsc_pkg::CONF_SPAN) begin
      conf = pfsc_pkg::CONF_MAX;
    end else begin
      conf = pfsc_pkg::CONF_HALF + quo[pfsc_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      lead_zero <= 1'b1;
      found     <= '0;
      total     <= '0;
    end else if (cmd.accept) begin
      if (last_byte) begin
        phase     <= PH_IDLE;
        lead_zero <= 1'b1;
        found     <= '0;
        total     <= '0;
      end else begin
        phase     <= phase_next;
        lead_zero <= lead_zero_next;
        found     <= found_next;
        total     <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_cap <= found_next;
      total_cap <= total_next;
      rem       <= prod[pfsc_pkg::PROD_W-1:4];
      quo       <= {prod[3:0], 16'b0};
      step_cnt  <= pfsc_pkg::STEP_W'(pfsc_pkg::DIV_STEPS - 1);
    end else if (cmd.step) begin
      rem      <= rem_next;
      quo      <= {quo[pfsc_pkg::DIV_STEPS-2:0], qbit};
      step_cnt <= step_cnt - 1'b1;
    end
    if (cmd.load) begin
      spec_count     <= pfsc_pkg::sat_out(found_cap);
      is_format      <= (found_cap != '0);
      confidence_q16 <= conf;
      text_length    <= pfsc_pkg::sat_out(total_cap);
    end
  end

endmodule

// ===== rtl/pfsc_ctrl.sv =====
// ---------------------------------------------------------------------------
// pfsc_ctrl - sequencing controller
// scan bytes, run the divider at string end, hand the result to the output
// ---------------------------------------------------------------------------
module pfsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pfsc_pkg::cmd_t    cmd,
  input  pfsc_pkg::status_t status
);

  typedef enum logic [2:0] {
    ST_SCAN = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  assign in_ready = (state == ST_SCAN);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_SCAN: begin
        cmd.accept = in_valid;
        cmd.start  = in_valid && in_last;
        if (in_valid && in_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_SCAN;
      end
    endcase
  end

  assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SCAN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/printf_format_spec_counter_core.sv =====
// ---------------------------------------------------------------------------
// printf_format_spec_counter_core - printf conversion specifier counter
// Counts complete printf conversion specifiers in a byte stream.
//
// text: one byte per beat, last_byte marks the end of a string. Bytes of a
//   string are taken one per cycle while no division runs and no result waits.
// result: one beat per string with the specifier count, a format flag,
//   the confidence in unsigned Q0.16 and the string length.
// After the beat with last_byte, a restoring divider computes
//   10*count/length one quotient bit per cycle; the result is loaded
//   into the output register once the divide is done, and text stays not
//   ready until then. Inside a string the rate is one byte per cycle.
// The result sits in an output register: the next string is taken while it
//   waits. If the receiver stalls, a finished result waits in the divider
//   until the output register is free, and text stays not ready meanwhile.
// rst (synchronous) clears the parser, the counters and the result valid.
// ---------------------------------------------------------------------------
`include "printf_format_spec_counter_core_assert.svh"

module printf_format_spec_counter_core (
  input  logic          clk,
  input  logic          rst,
  pfsc_text_if.sink     text,
  pfsc_result_if.source result
);

  pfsc_pkg::cmd_t    cmd;
  pfsc_pkg::status_t status;

  pfsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text.valid),
    .in_last   (text.last_byte),
    .in_ready  (text.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  pfsc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .text_byte      (text.text_byte),
    .last_byte      (text.last_byte),
    .cmd            (cmd),
    .status         (status),
    .spec_count     (result.spec_count),
    .is_format      (result.is_format),
    .confidence_q16 (result.confidence_q16),
    .text_length    (result.text_length)
  );

  `PFSC_ASSERT_IMP(a_no_byte_during_div, cmd.step, !text.ready, "byte taken during divide")
  `PFSC_ASSERT_IMP(a_load_when_free, cmd.load, !result.valid || result.ready,
                   "pending result overwritten")
  `PFSC_ASSERT_NEXT(a_div_follows_last, text.valid && text.ready && text.last_byte,
                    cmd.step, "divide did not start after last byte")
  `PFSC_ASSERT_NEXT(a_valid_after_load, cmd.load, result.valid, "loaded result not valid")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - printf format specifier counter testbench
// Streams strings into the counter a byte per beat and checks each end-of-string
// summary against an in-bench scanner of the same grammar, or the table value
// for typed rows. A short directed table comes first, then random strings built
// mostly from well-formed specifiers, run under three idle patterns. The receiver
// also stalls once for a long stretch so that the core backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SC_IDLE, SC_PCT, SC_POS, SC_FLAGS, SC_WID, SC_AWID,
    SC_DOT, SC_PREC, SC_APREC, SC_H, SC_L, SC_LEN
  } scan_e;

  typedef struct packed {
    logic [15:0] spec_count;
    logic        is_format;
    logic [15:0] confidence_q16;
    logic [15:0] text_length;
  } summary_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       typed;
    summary_t   want;
  } dir_row_t;

  localparam summary_t NONE = '0;
  localparam string DIGITS   = "0123456789";
  localparam string FLAG_SET = "-+ #0'";
  localparam string CONV_SET = "diuoxXfFeEgGaAcspnm";
  localparam string LEN_SET  = "jztL";
  localparam string MIX_SET  = "%0123456789$.*-+ #'hljztLdxsq";
  localparam logic [7:0] CH_D = "d";
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       tx_valid = 1'b0;
  logic [7:0] tx_byte  = 8'h00;
  logic       tx_last  = 1'b0;
  logic       rx_ready = 1'b0;

  pfsc_text_if   text_ch ();
  pfsc_result_if result_ch ();

  assign text_ch.valid     = tx_valid;
  assign text_ch.text_byte = tx_byte;
  assign text_ch.last_byte = tx_last;
  assign result_ch.ready   = rx_ready;

  printf_format_spec_counter_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  always #6 clk = ~clk;

  // scanner state
  scan_e       scan_st    = SC_IDLE;
  logic        zeros_only = 1'b1;
  int unsigned spec_seen  = 0;
  int unsigned byte_seen  = 0;

  summary_t summary_q [$];
  int       errors    = 0;
  int       send_idle = 0;
  int       recv_idle = 0;

  dir_row_t dir_tab [25] = '{
    '{8'h00,    1'b1, 1'b1, '{16'd0, 1'b0, 16'd0, 16'd1}},
    '{8'hFF,    1'b1, 1'b1, '{16'd0, 1'b0, 16'd0, 16'd1}},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{CH_D,     1'b1, 1'b1, '{16'd1, 1'b1, pfsc_pkg::CONF_MAX, 16'd2}},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_PCT,   1'b1, 1'b1, '{16'd0, 1'b0, 16'd0, 16'd2}},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{"1",      1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_DOLLAR, 1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_MINUS, 1'b0, 1'b0, NONE},
    '{CH_D,     1'b1, 1'b0, NONE},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_ZERO,  1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_ZERO,  1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_MINUS, 1'b0, 1'b0, NONE},
    '{CH_D,     1'b1, 1'b0, NONE},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_MINUS, 1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{CH_D,     1'b1, 1'b0, NONE},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{"5",      1'b1, 1'b1, '{16'd0, 1'b0, 16'd0, 16'd2}},
    '{pfsc_pkg::CH_PCT,   1'b0, 1'b0, NONE},
    '{pfsc_pkg::CH_LOW_H, 1'b0, 1'b0, NONE},
    '{"X",      1'b1, 1'b0, NONE}
  };

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= pfsc_pkg::CH_ZERO) && (c <= pfsc_pkg::CH_NINE);
  endfunction

  function automatic logic char_in(input string set, input logic [7:0] c);
    for (int i = 0; i < set.len(); i++) begin
      if (set[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // one byte through the specifier grammar; failures fall through to the idle check
  function automatic scan_e scan_next(input scan_e cur, input logic [7:0] c);
    scan_e st;
    st = cur;
    if (st == SC_PCT) begin
      if (c == pfsc_pkg::CH_PCT) return SC_IDLE;
      if (is_dig(c)) begin
        zeros_only = (c == pfsc_pkg::CH_ZERO);
        return SC_POS;
      end
      st = SC_FLAGS;
    end
    if (st == SC_POS) begin
      if (is_dig(c)) begin
        zeros_only = zeros_only && (c == pfsc_pkg::CH_ZERO);
        return SC_POS;
      end
      if (c == pfsc_pkg::CH_DOLLAR) return SC_FLAGS;
      st = zeros_only ? SC_FLAGS : SC_AWID;
    end
    if (st == SC_FLAGS) begin
      if (char_in(FLAG_SET, c)) return SC_FLAGS;
      if (c == pfsc_pkg::CH_STAR) return SC_AWID;
      if (is_dig(c)) return SC_WID;
      st = SC_AWID;
    end
    if (st == SC_WID) begin
      if (is_dig(c)) return SC_WID;
      st = SC_AWID;
    end
    if (st == SC_AWID) begin
      if (c == pfsc_pkg::CH_DOT) return SC_DOT;
      st = SC_APREC;
    end
    if (st == SC_DOT) begin
      if (c == pfsc_pkg::CH_STAR) return SC_APREC;
      if (is_dig(c)) return SC_PREC;
      st = SC_APREC;
    end
    if (st == SC_PREC) begin
      if (is_dig(c)) return SC_PREC;
      st = SC_APREC;
    end
    if (st == SC_APREC) begin
      if (c == pfsc_pkg::CH_LOW_H) return SC_H;
      if (c == pfsc_pkg::CH_LOW_L) return SC_L;
      if (char_in(LEN_SET, c)) return SC_LEN;
      st = SC_LEN;
    end
    if (st == SC_H) begin
      if (c == pfsc_pkg::CH_LOW_H) return SC_LEN;
      st = SC_LEN;
    end
    if (st == SC_L) begin
      if (c == pfsc_pkg::CH_LOW_L) return SC_LEN;
      st = SC_LEN;
    end
    if (st == SC_LEN && char_in(CONV_SET, c)) begin
      if (spec_seen < pfsc_pkg::CNT_MAX) spec_seen++;
      return SC_IDLE;
    end
    return (c == pfsc_pkg::CH_PCT) ? SC_PCT : SC_IDLE;
  endfunction

  // returns 1 with the string summary on the last byte
  function automatic logic predict_summary(input logic [7:0] c, input logic last,
                                           output summary_t s);
    longint unsigned dens;
    s = '0;
    if (byte_seen < pfsc_pkg::CNT_MAX) byte_seen++;
    scan_st = scan_next(scan_st, c);
    if (!last) return 1'b0;
    if (spec_seen != 0) begin
      dens = (64'd655360 * spec_seen) / byte_seen;
      s.confidence_q16 = (dens >= (pfsc_pkg::CONF_MAX - pfsc_pkg::CONF_HALF))
                         ? pfsc_pkg::CONF_MAX
                         : 16'(pfsc_pkg::CONF_HALF + dens);
    end
    s.spec_count  = 16'(spec_seen);
    s.is_format   = (spec_seen != 0);
    s.text_length = 16'(byte_seen);
    scan_st    = SC_IDLE;
    zeros_only = 1'b1;
    spec_seen  = 0;
    byte_seen  = 0;
    return 1'b1;
  endfunction

  function automatic void gen_spec(ref logic [7:0] q[$]);
    q.push_back(pfsc_pkg::CH_PCT);
    case ($urandom_range(9))
      0, 1: begin
        repeat ($urandom_range(1, 2)) q.push_back(pick(DIGITS));
        q.push_back(pfsc_pkg::CH_DOLLAR);
      end
      2: repeat ($urandom_range(1, 2)) q.push_back(pfsc_pkg::CH_ZERO);
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) q.push_back(pick(FLAG_SET));
    case ($urandom_range(3))
      1: q.push_back(pfsc_pkg::CH_STAR);
      2, 3: repeat ($urandom_range(1, 3)) q.push_back(pick(DIGITS));
      default: ;
    endcase
    if ($urandom_range(99) < 35) begin
      q.push_back(pfsc_pkg::CH_DOT);
      case ($urandom_range(2))
        0: q.push_back(pfsc_pkg::CH_STAR);
        1: repeat ($urandom_range(1, 2)) q.push_back(pick(DIGITS));
        default: ;
      endcase
    end
    case ($urandom_range(8))
      0: q.push_back(pfsc_pkg::CH_LOW_H);
      1: begin q.push_back(pfsc_pkg::CH_LOW_H); q.push_back(pfsc_pkg::CH_LOW_H); end
      2: q.push_back(pfsc_pkg::CH_LOW_L);
      3: begin q.push_back(pfsc_pkg::CH_LOW_L); q.push_back(pfsc_pkg::CH_LOW_L); end
      4: q.push_back(pick(LEN_SET));
      default: ;
    endcase
    q.push_back(pick(CONV_SET));
  endfunction

  function automatic void gen_text(ref logic [7:0] q[$]);
    logic [7:0] part[$];
    int target;
    int k;
    int cut;
    q.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
    while (q.size() < target) begin
      k = $urandom_range(99);
      if (k < 50) begin
        gen_spec(q);
      end else if (k < 62) begin
        q.push_back(8'($urandom_range(255)));
      end else if (k < 70) begin
        q.push_back(pfsc_pkg::CH_PCT);
        q.push_back(pfsc_pkg::CH_PCT);
      end else if (k < 85) begin
        // broken specifier: cut short or one byte replaced
        part.delete();
        gen_spec(part);
        if ($urandom_range(1)) begin
          cut = $urandom_range(part.size() - 2);
          for (int i = 0; i <= cut; i++) q.push_back(part[i]);
        end else begin
          part[$urandom_range(part.size() - 1)] = 8'($urandom_range(255));
          foreach (part[i]) q.push_back(part[i]);
        end
      end else begin
        q.push_back(pick(MIX_SET));
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= 50)
      $display("[%0t] result mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic l,
                          input logic typed = 1'b0, input summary_t want = '0);
    summary_t s;
    while ($urandom_range(99) < send_idle) begin
      tx_valid <= 1'b0;
      @(posedge clk);
    end
    tx_valid <= 1'b1;
    tx_byte  <= b;
    tx_last  <= l;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    if (predict_summary(b, l, s)) summary_q.push_back(typed ? want : s);
  endtask

  task automatic send_text(ref logic [7:0] q[$]);
    foreach (q[i]) put_byte(q[i], i == q.size() - 1);
  endtask

  // receiver: random ready, one long hold after the third beat
  int unsigned hold_left   = 0;
  int unsigned beats_taken = 0;
  logic        held        = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else begin
      if (result_ch.valid && rx_ready) beats_taken <= beats_taken + 1;
      if (result_ch.valid && rx_ready && beats_taken == 2 && !held) begin
        hold_left <= HOLD_CYCLES;
        held      <= 1'b1;
        rx_ready  <= 1'b0;
      end else begin
        rx_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    summary_t w;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (summary_q.size() == 0) begin
        report_mismatch("unexpected beat, spec_count", result_ch.spec_count, 0);
      end else begin
        w = summary_q.pop_front();
        if (result_ch.spec_count !== w.spec_count)
          report_mismatch("spec_count", result_ch.spec_count, w.spec_count);
        if (result_ch.is_format !== w.is_format)
          report_mismatch("is_format", result_ch.is_format, w.is_format);
        if (result_ch.confidence_q16 !== w.confidence_q16)
          report_mismatch("confidence_q16", result_ch.confidence_q16, w.confidence_q16);
        if (result_ch.text_length !== w.text_length)
          report_mismatch("text_length", result_ch.text_length, w.text_length);
      end
    end
  end

  initial begin
    logic [7:0] str_q[$];
    int sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 10 : (ph == 1) ? 65 : 0;
      recv_idle = (ph == 0) ? 65 : (ph == 1) ? 10 : 0;
      if (ph == 0) begin
        foreach (dir_tab[i])
          put_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
      end
      sent = 0;
      while (sent < 200) begin
        gen_text(str_q);
        send_text(str_q);
        sent += str_q.size();
      end
    end
    tx_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pfsc_pkg.sv
rtl/pfsc_text_if.sv
rtl/pfsc_result_if.sv
rtl/pfsc_datapath.sv
rtl/pfsc_ctrl.sv
rtl/printf_format_spec_counter_core.sv
sim/tb_top.sv
